[sv/bme_pkg.sv]
// Shared types, constants and helper functions for the bitset membership engine.
// No dependencies; imported by the engine unit and the bench (bme_ram does not use it).
package bme_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int WORD_BITS    = 32;
    localparam int NUM_WORDS    = (MAX_ELEMENTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W      = $clog2(NUM_WORDS);
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int IDX_W        = $clog2(NUM_WORDS + 1);
    localparam int ELEM_W       = 10;
    localparam int CMD_W        = 3;
    localparam int COUNT_W      = 11;
    localparam int UNI_W        = 11;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 2;
    localparam int S_DATA_W     = 16;
    localparam int S_USER_W     = 8;
    localparam int M_DATA_W     = 24;
    localparam int RES_W        = 1 + ELEM_W + 1 + COUNT_W;

    localparam logic [UNI_W-1:0] UNI_RESET = UNI_W'(MAX_ELEMENTS);
    localparam logic [UNI_W-1:0] UNI_MAX   = UNI_W'(MAX_ELEMENTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_FILL   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SWEEP,
        ST_LOAD
    } state_t;

    // Position of the lowest set bit; zero for an empty word
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // Word w of a set that holds every element below n
    function automatic logic [WORD_BITS-1:0] fill_word(input logic [UNI_W-1:0] n,
                                                        input logic [WADDR_W-1:0] w);
        logic [UNI_W:0]         base;
        logic [UNI_W:0]         top;
        logic [UNI_W:0]         rem;
        logic [WORD_BITS-1:0]   r;
        base = (UNI_W+1)'(w) << BIT_W;
        top  = base + (UNI_W+1)'(WORD_BITS);
        rem  = {1'b0, n} - base;
        if (top <= {1'b0, n}) begin
            r = '1;
        end else if (base < {1'b0, n}) begin
            r = (WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1);
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

[sv/bitset_membership_engine_unit.sv]
// Bitset membership engine: 32 words of set bits in a RAM plus a member count.
// Test, add and remove read the element's word, then load the result; find goes straight to
// the result on an empty set, else scans one word read per cycle up to the first non-zero
// word; clear and fill sweep one word written per cycle; unused codes go straight to the
// result. One word in flight: s_tready returns once m_tvalid rises.
// Reset (aresetn low, synchronous) marks every word unwritten, zeroes count, universe 1024.
module bitset_membership_engine_unit
    import bme_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input word
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [9:0] element
    input  logic [S_USER_W-1:0]  s_tuser,   // [2:0] cmd
    // result word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [0] was_member, [10:1] lowest_member,
                                            // [11] set_empty, [22:12] member_count
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [ELEM_W-1:0]      elem_reg, elem_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [NUM_WORDS-1:0]   word_valid_reg, word_valid_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [UNI_W-1:0]       universe_reg, universe_next;
    logic                   res_was_reg, res_was_next;
    logic [ELEM_W-1:0]      res_low_reg, res_low_next;
    logic                   m_valid_reg, m_valid_next;
    logic [RES_W-1:0]       m_data_reg, m_data_next;

    logic                   in_fire;
    logic                   out_free;
    logic                   ram_we;
    logic [WADDR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;
    logic [WORD_BITS-1:0]   cur_word;
    logic [UNI_W-1:0]       n_act;
    logic                   in_uni;
    logic                   hit;
    logic [WORD_BITS-1:0]   bit_mask;
    logic [WADDR_W-1:0]     elem_word;
    logic [WADDR_W-1:0]     pend_addr;
    logic                   scan_done;
    logic                   sweep_last;
    logic [ELEM_W-1:0]      in_elem;
    cmd_t                   in_cmd;

    assign in_elem   = s_tdata[ELEM_W-1:0];
    assign in_cmd    = cmd_t'(s_tuser[CMD_W-1:0]);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign n_act     = (universe_reg > UNI_MAX) ? UNI_MAX : universe_reg;
    assign cur_word  = rd_valid_reg ? ram_rdata : '0;
    assign elem_word = elem_reg[ELEM_W-1:BIT_W];
    assign in_uni    = {1'b0, elem_reg} < n_act;
    assign bit_mask  = WORD_BITS'(1) << elem_reg[BIT_W-1:0];
    assign hit       = in_uni && ((cur_word & bit_mask) != '0);
    assign pend_addr = WADDR_W'(idx_reg - IDX_W'(1));
    assign scan_done = !pend_reg && (idx_reg == IDX_W'(NUM_WORDS));
    assign sweep_last = (idx_reg == IDX_W'(NUM_WORDS - 1));

    // Configuration port: a single register, every address maps to it
    assign pready = 1'b1;
    assign prdata = APB_DW'(universe_reg);

    // Result channel
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

    // Word store
    bme_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_words (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_cmd)
                        CMD_TEST, CMD_ADD, CMD_REMOVE: state_next = ST_READ;
                        CMD_FIND:  state_next = (count_reg != '0) ? ST_SCAN : ST_LOAD;
                        CMD_CLEAR, CMD_FILL: state_next = ST_SWEEP;
                        default:   state_next = ST_LOAD;
                    endcase
                end
            end
            ST_READ: state_next = ST_LOAD;
            ST_SCAN: begin
                if ((pend_reg && (cur_word != '0)) || scan_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_SWEEP: begin
                if (sweep_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        cmd_next        = cmd_reg;
        elem_next       = elem_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        word_valid_next = word_valid_reg;
        count_next      = count_reg;
        universe_next   = universe_reg;
        res_was_next    = res_was_reg;
        res_low_next    = res_low_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = elem_word;
        ram_wdata       = '0;
        ram_raddr       = elem_word;

        // Register write on the APB access cycle
        if (psel && penable && pwrite) begin
            universe_next = pwdata[UNI_W-1:0];
        end

        // Drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // Latch the command and start the read of its word
                ram_raddr = in_elem[ELEM_W-1:BIT_W];
                if (in_fire) begin
                    cmd_next     = in_cmd;
                    elem_next    = in_elem;
                    idx_next     = '0;
                    res_was_next = 1'b0;
                    res_low_next = '0;
                end
            end
            ST_READ: begin
                res_was_next = hit;
                if (cmd_reg == CMD_ADD && in_uni && !hit) begin
                    ram_we                     = 1'b1;
                    ram_wdata                  = cur_word | bit_mask;
                    word_valid_next[elem_word] = 1'b1;
                    count_next                 = count_reg + COUNT_W'(1);
                end else if (cmd_reg == CMD_REMOVE && hit) begin
                    ram_we                     = 1'b1;
                    ram_wdata                  = cur_word & ~bit_mask;
                    word_valid_next[elem_word] = 1'b1;
                    count_next                 = count_reg - COUNT_W'(1);
                end
            end
            ST_SCAN: begin
                // Issue the next read while checking the word that came back
                ram_raddr = idx_reg[WADDR_W-1:0];
                if (pend_reg && (cur_word != '0)) begin
                    res_low_next = ELEM_W'({pend_addr, lowest_bit(cur_word)});
                end else if (idx_reg != IDX_W'(NUM_WORDS)) begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            ST_SWEEP: begin
                // Write one word per cycle
                ram_we    = 1'b1;
                ram_waddr = idx_reg[WADDR_W-1:0];
                ram_wdata = (cmd_reg == CMD_FILL) ? fill_word(n_act, idx_reg[WADDR_W-1:0])
                                                  : '0;
                word_valid_next[idx_reg[WADDR_W-1:0]] = 1'b1;
                idx_next  = idx_reg + IDX_W'(1);
                if (sweep_last) begin
                    count_next = (cmd_reg == CMD_FILL) ? COUNT_W'(n_act) : '0;
                end
            end
            ST_LOAD: begin
                // Hand the result to the output register
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {count_reg, (count_reg == '0), res_low_reg, res_was_reg};
                end
            end
            default: ;
        endcase

        rd_valid_next = word_valid_reg[ram_raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_reg       <= 1'b0;
            word_valid_reg <= '0;
            count_reg      <= '0;
            universe_reg   <= UNI_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            word_valid_reg <= word_valid_next;
            count_reg      <= count_next;
            universe_reg   <= universe_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        elem_reg     <= elem_next;
        idx_reg      <= idx_next;
        rd_valid_reg <= rd_valid_next;
        res_was_reg  <= res_was_next;
        res_low_reg  <= res_low_next;
        m_data_reg   <= m_data_next;
    end

endmodule

[sv/bme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/tb_top.sv]
// Self-checking bench for bitset_membership_engine_unit: directed table, then random phases.
// Depends on bme_pkg and the engine RTL; an in-bench set model predicts each result word.
module tb_top
    import bme_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT   = 400_000;
    localparam int          SETTLE_CYCLES = NUM_WORDS + 8;
    localparam int          PHASE_WORDS   = 82;
    localparam int          N_DIRECTED    = 32;
    localparam int          N_PHASES      = 8;
    localparam int          REG_UNIVERSE  = 0;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic               was;
        logic [ELEM_W-1:0]  lowest;
        logic               empty;
        logic [COUNT_W-1:0] count;
    } result_t;

    typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CMD_W-1:0]   cmd;
        logic [UNI_W-1:0]   value;   // element for a word, register value for a write
        bit                 typed;
        result_t            want;
    } plan_row_t;

    localparam result_t NO_WANT = '0;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;    // [9:0] element
    logic [S_USER_W-1:0]  s_tuser  = '0;    // [2:0] cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;          // [0] was_member, [10:1] lowest_member,
                                            // [11] set_empty, [22:12] member_count
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Set model and bookkeeping
    logic [MAX_ELEMENTS-1:0] model_members  = '0;
    int unsigned             model_count    = 0;
    logic [UNI_W-1:0]        model_universe = UNI_RESET;
    result_t                 pending_results [$];
    bit                      calm = 1'b0;
    int unsigned             mismatches = 0;
    int unsigned             words_sent = 0;
    int unsigned             words_checked = 0;
    int unsigned             finds_hit = 0;
    int unsigned             settings_used = 1;
    int unsigned             cycles = 0;

    bitset_membership_engine_unit uut (.*);

    // Directed words; typed rows carry a result read straight off the set's behaviour
    plan_row_t directed_plan [N_DIRECTED] = '{
        // fresh from reset: empty set, full universe
        '{ROW_WORD, CMD_FIND,    11'd0,    1'b1, '{1'b0, 10'd0,    1'b1, 11'd0}},
        '{ROW_WORD, CMD_TEST,    11'd0,    1'b1, '{1'b0, 10'd0,    1'b1, 11'd0}},
        '{ROW_WORD, CMD_ADD,     11'd1023, 1'b1, '{1'b0, 10'd0,    1'b0, 11'd1}},
        '{ROW_WORD, CMD_ADD,     11'd1023, 1'b1, '{1'b1, 10'd0,    1'b0, 11'd1}},
        '{ROW_WORD, CMD_FIND,    11'd0,    1'b1, '{1'b0, 10'd1023, 1'b0, 11'd1}},
        '{ROW_WORD, CMD_ADD,     11'd0,    1'b1, '{1'b0, 10'd0,    1'b0, 11'd2}},
        '{ROW_WORD, CMD_FIND,    11'd0,    1'b1, '{1'b0, 10'd0,    1'b0, 11'd2}},
        '{ROW_WORD, CMD_REMOVE,  11'd0,    1'b1, '{1'b1, 10'd0,    1'b0, 11'd1}},
        '{ROW_WORD, CMD_REMOVE,  11'd0,    1'b1, '{1'b0, 10'd0,    1'b0, 11'd1}},
        // unused codes leave the set alone
        '{ROW_WORD, CMD_SPARE_6, 11'd5,    1'b1, '{1'b0, 10'd0,    1'b0, 11'd1}},
        '{ROW_WORD, CMD_SPARE_7, 11'd1023, 1'b1, '{1'b0, 10'd0,    1'b0, 11'd1}},
        '{ROW_WORD, CMD_FILL,    11'd0,    1'b1, '{1'b0, 10'd0,    1'b0, 11'd1024}},
        '{ROW_WORD, CMD_REMOVE,  11'd1023, 1'b0, NO_WANT},
        '{ROW_WORD, CMD_FIND,    11'd0,    1'b0, NO_WANT},
        '{ROW_WORD, CMD_CLEAR,   11'd0,    1'b1, '{1'b0, 10'd0,    1'b1, 11'd0}},
        // small universe: indices at or above it are ignored
        '{ROW_REG,  CMD_TEST,    11'd40,   1'b0, NO_WANT},
        '{ROW_WORD, CMD_ADD,     11'd39,   1'b0, NO_WANT},
        '{ROW_WORD, CMD_ADD,     11'd40,   1'b0, NO_WANT},
        '{ROW_WORD, CMD_TEST,    11'd40,   1'b0, NO_WANT},
        '{ROW_WORD, CMD_FILL,    11'd0,    1'b0, NO_WANT},
        // universe above the maximum acts as the maximum
        '{ROW_REG,  CMD_TEST,    11'd2047, 1'b0, NO_WANT},
        '{ROW_WORD, CMD_FILL,    11'd0,    1'b1, '{1'b0, 10'd0,    1'b0, 11'd1024}},
        // shrink to nothing: kept members stay counted and findable
        '{ROW_REG,  CMD_TEST,    11'd0,    1'b0, NO_WANT},
        '{ROW_WORD, CMD_TEST,    11'd5,    1'b0, NO_WANT},
        '{ROW_WORD, CMD_REMOVE,  11'd5,    1'b0, NO_WANT},
        '{ROW_WORD, CMD_FIND,    11'd0,    1'b0, NO_WANT},
        '{ROW_WORD, CMD_ADD,     11'd1023, 1'b0, NO_WANT},
        '{ROW_WORD, CMD_FILL,    11'd0,    1'b1, '{1'b0, 10'd0,    1'b1, 11'd0}},
        '{ROW_WORD, CMD_FIND,    11'd0,    1'b1, '{1'b0, 10'd0,    1'b1, 11'd0}},
        // universe of one element
        '{ROW_REG,  CMD_TEST,    11'd1,    1'b0, NO_WANT},
        '{ROW_WORD, CMD_FILL,    11'd0,    1'b0, NO_WANT},
        '{ROW_WORD, CMD_TEST,    11'd0,    1'b0, NO_WANT}
    };

    // Apply one command to the set model and return the result word it yields
    function automatic result_t apply_set_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [ELEM_W-1:0] elem);
        result_t     r;
        int unsigned lim;
        logic        present;
        r       = '0;
        lim     = (model_universe > UNI_MAX) ? MAX_ELEMENTS : int'(model_universe);
        present = (elem < lim) && model_members[elem];
        case (cmd)
            CMD_TEST: begin
                r.was = present;
            end
            CMD_ADD: begin
                r.was = present;
                if (elem < lim && !present) begin
                    model_members[elem] = 1'b1;
                    model_count++;
                end
            end
            CMD_REMOVE: begin
                r.was = present;
                if (present) begin
                    model_members[elem] = 1'b0;
                    model_count--;
                end
            end
            CMD_FIND: begin
                // walk down so the last hit is the lowest member, whatever the universe
                if (model_count != 0) begin
                    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
                        if (model_members[i]) begin
                            r.lowest = ELEM_W'(i);
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                model_members = '0;
                model_count   = 0;
            end
            CMD_FILL: begin
                for (int i = 0; i < MAX_ELEMENTS; i++) begin
                    model_members[i] = (i < lim);
                end
                model_count = lim;
            end
            default: begin
            end
        endcase
        r.empty = (model_count == 0);
        r.count = COUNT_W'(model_count);
        return r;
    endfunction

    // Offer one command word, idling at random beforehand, and log its expected result
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] elem,
                                input bit typed, input result_t typed_want);
        result_t predicted;
        while (!calm && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= S_USER_W'(cmd);
        s_tdata  <= S_DATA_W'(elem);
        do @(posedge aclk); while (!s_tready);
        predicted = apply_set_command(cmd, elem);
        pending_results.push_back(typed ? typed_want : predicted);
        words_sent++;
        if (cmd == CMD_FIND && !predicted.empty) begin
            finds_hit++;
        end
    endtask

    // Hold the sender off until every outstanding result word has been taken
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Setup then access phase; the register takes the value at the access edge
    task automatic write_universe(input logic [UNI_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * REG_UNIVERSE);
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_universe = value;
        settings_used++;
    endtask

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: want was=%0d low=%0d empty=%0d count=%0d,",
                     $realtime, what, want.was, want.lowest, want.empty, want.count);
            $display("    got was=%0d low=%0d empty=%0d count=%0d",
                     got.was, got.lowest, got.empty, got.count);
        end
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver back-pressure, switched off during the calm phase
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 18);
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.was    = m_tdata[0];
            got.lowest = m_tdata[10:1];
            got.empty  = m_tdata[11];
            got.count  = m_tdata[22:12];
            words_checked++;
            if (pending_results.size() == 0) begin
                note_mismatch("result word with nothing expected", NO_WANT, got);
            end else begin
                want = pending_results.pop_front();
                if (got.was !== want.was || got.lowest !== want.lowest ||
                    got.empty !== want.empty || got.count !== want.count) begin
                    note_mismatch("result word differs", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic [UNI_W-1:0]  universes [N_PHASES];
        logic [CMD_W-1:0]  cmd;
        logic [ELEM_W-1:0] elem;
        int unsigned       pick;
        int unsigned       lim;
        int unsigned       window;

        universes = '{11'd300, 11'd2047, 11'd1024, 11'd1, 11'd0, 11'd777, 11'd64, 11'd1024};
        universes[6] = UNI_W'($urandom_range(1023, 2));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table
        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_REG) begin
                wait_results_drained();
                write_universe(directed_plan[i].value);
            end else begin
                send_command(directed_plan[i].cmd, directed_plan[i].value[ELEM_W-1:0],
                             directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // random phases, one universe setting each
        for (int p = 0; p < N_PHASES; p++) begin
            wait_results_drained();
            write_universe(universes[p]);
            calm   = (p == 2);
            lim    = (universes[p] > UNI_MAX) ? MAX_ELEMENTS : int'(universes[p]);
            window = (lim > 48) ? $urandom_range(lim - 48) : 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(99);
                if (pick < 33)      cmd = CMD_ADD;
                else if (pick < 53) cmd = CMD_REMOVE;
                else if (pick < 71) cmd = CMD_TEST;
                else if (pick < 86) cmd = CMD_FIND;
                else if (pick < 90) cmd = CMD_CLEAR;
                else if (pick < 95) cmd = CMD_FILL;
                else if (pick < 97) cmd = CMD_SPARE_6;
                else                cmd = CMD_SPARE_7;
                // mostly cluster around a window so finds and removes interact
                if ($urandom_range(3) == 0) begin
                    elem = ELEM_W'($urandom_range(1023));
                end else begin
                    elem = ELEM_W'(window + $urandom_range(47));
                end
                send_command(cmd, elem, 1'b0, NO_WANT);
                // drain mid-phase once to check the block settles with the sender held off
                if (p == 4 && n == PHASE_WORDS / 2) begin
                    wait_results_drained();
                end
            end
        end
        calm = 1'b0;

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d command words (%0d checked) over %0d universe settings,",
                 words_sent, words_checked, settings_used);
        $display("with %0d find-lowest hits on a non-empty set and %0d mismatches.",
                 finds_hit, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
